### rtl/core/qprod_pkg.sv
// Shared constants for the quaternion product pipeline.
package qprod_pkg;

  localparam int NUM_COMP = 4;
  localparam int NUM_PROD = 8;

  localparam int COMP_W = 0;
  localparam int COMP_X = 1;
  localparam int COMP_Y = 2;
  localparam int COMP_Z = 3;

endpackage

### rtl/core/qprod_mul.sv
// Pre-add and multiply stages: eight factored products of pairwise sums and differences.
module qprod_mul #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [COMPONENT_WIDTH-1:0]   left_w,
  input  logic signed [COMPONENT_WIDTH-1:0]   left_x,
  input  logic signed [COMPONENT_WIDTH-1:0]   left_y,
  input  logic signed [COMPONENT_WIDTH-1:0]   left_z,
  input  logic signed [COMPONENT_WIDTH-1:0]   right_w,
  input  logic signed [COMPONENT_WIDTH-1:0]   right_x,
  input  logic signed [COMPONENT_WIDTH-1:0]   right_y,
  input  logic signed [COMPONENT_WIDTH-1:0]   right_z,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic signed [2*COMPONENT_WIDTH+1:0] prod [qprod_pkg::NUM_PROD]
);

  localparam int PW = COMPONENT_WIDTH + 1;
  localparam int MW = 2 * COMPONENT_WIDTH + 2;

  logic signed [PW-1:0] aw, ax, ay, az, bw, bx, by, bz;
  logic signed [PW-1:0] la_nxt [qprod_pkg::NUM_PROD];
  logic signed [PW-1:0] rb_nxt [qprod_pkg::NUM_PROD];
  logic signed [PW-1:0] la_r   [qprod_pkg::NUM_PROD];
  logic signed [PW-1:0] rb_r   [qprod_pkg::NUM_PROD];
  logic signed [MW-1:0] m_r    [qprod_pkg::NUM_PROD];
  logic                 v1_r, v2_r;
  logic                 en1, en2;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;

  always_comb begin
    aw = PW'(left_w);
    ax = PW'(left_x);
    ay = PW'(left_y);
    az = PW'(left_z);
    bw = PW'(right_w);
    bx = PW'(right_x);
    by = PW'(right_y);
    bz = PW'(right_z);
    la_nxt[0] = az - ay;  rb_nxt[0] = by - bz;
    la_nxt[1] = aw + ax;  rb_nxt[1] = bw + bx;
    la_nxt[2] = aw - ax;  rb_nxt[2] = by + bz;
    la_nxt[3] = ay + az;  rb_nxt[3] = bw - bx;
    la_nxt[4] = az - ax;  rb_nxt[4] = bx - by;
    la_nxt[5] = az + ax;  rb_nxt[5] = bx + by;
    la_nxt[6] = aw + ay;  rb_nxt[6] = bw - bz;
    la_nxt[7] = aw - ay;  rb_nxt[7] = bw + bz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < qprod_pkg::NUM_PROD; i++) begin
      if (en1) begin
        la_r[i] <= la_nxt[i];
        rb_r[i] <= rb_nxt[i];
      end
      if (en2) m_r[i] <= la_r[i] * rb_r[i];
    end
  end

  assign prod = m_r;

endmodule

### rtl/core/qprod_combine.sv
// Combine stages: common term, halving and unrounded output sums.
module qprod_combine #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [2*COMPONENT_WIDTH+1:0] prod [qprod_pkg::NUM_PROD],
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic signed [2*COMPONENT_WIDTH+5:0] sum [qprod_pkg::NUM_COMP]
);

  localparam int SW = 2 * COMPONENT_WIDTH + 6;

  logic signed [SW-1:0] m3_r [qprod_pkg::NUM_PROD];
  logic signed [SW-1:0] s56_r, s47_r;
  logic signed [SW-1:0] m4_r [qprod_pkg::NUM_PROD];
  logic signed [SW-1:0] s8_r, h_r;
  logic signed [SW-1:0] o_r  [qprod_pkg::NUM_COMP];
  logic signed [SW-1:0] h_nxt;
  logic                 v3_r, v4_r, v5_r;
  logic                 en3, en4, en5;

  assign en5      = !v5_r || dn_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;
  assign dn_valid = v5_r;

  assign h_nxt = (s56_r + s47_r) >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) v3_r <= up_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < qprod_pkg::NUM_PROD; i++) m3_r[i] <= SW'(prod[i]);
      s56_r <= SW'(prod[5]) + SW'(prod[6]);
      s47_r <= SW'(prod[4]) + SW'(prod[7]);
    end
    if (en4) begin
      m4_r <= m3_r;
      s8_r <= s56_r + m3_r[7];
      h_r  <= h_nxt;
    end
    if (en5) begin
      o_r[qprod_pkg::COMP_W] <= m4_r[0] + h_r - m4_r[5];
      o_r[qprod_pkg::COMP_X] <= m4_r[1] + h_r - s8_r;
      o_r[qprod_pkg::COMP_Y] <= m4_r[2] + h_r - m4_r[7];
      o_r[qprod_pkg::COMP_Z] <= m4_r[3] + h_r - m4_r[6];
    end
  end

  assign sum = o_r;

endmodule

### rtl/core/qprod_round.sv
// Output stage: round to nearest, saturate and hold the result register.
module qprod_round #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [2*COMPONENT_WIDTH+5:0] sum [qprod_pkg::NUM_COMP],
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COMPONENT_WIDTH-1:0]   prod_w,
  output logic signed [COMPONENT_WIDTH-1:0]   prod_x,
  output logic signed [COMPONENT_WIDTH-1:0]   prod_y,
  output logic signed [COMPONENT_WIDTH-1:0]   prod_z,
  output logic                                saturated
);

  localparam int SW = 2 * COMPONENT_WIDTH + 6;
  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [COMPONENT_WIDTH-1:0] MAX_VAL =
    {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [COMPONENT_WIDTH-1:0] MIN_VAL =
    {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  logic signed [SW-1:0]              sh    [qprod_pkg::NUM_COMP];
  logic signed [COMPONENT_WIDTH-1:0] c_nxt [qprod_pkg::NUM_COMP];
  logic signed [COMPONENT_WIDTH-1:0] c_r   [qprod_pkg::NUM_COMP];
  logic [qprod_pkg::NUM_COMP-1:0]    clip;
  logic                              sat_r;
  logic                              v6_r;
  logic                              en6;

  assign en6      = !v6_r || !out_stall;
  assign up_ready = en6;

  always_comb begin
    for (int i = 0; i < qprod_pkg::NUM_COMP; i++) begin
      sh[i]   = (sum[i] + HALF_LSB) >>> FRACTION_BITS;
      clip[i] = !((&sh[i][SW-1:COMPONENT_WIDTH-1]) || !(|sh[i][SW-1:COMPONENT_WIDTH-1]));
      if (clip[i]) begin
        c_nxt[i] = sh[i][SW-1] ? MIN_VAL : MAX_VAL;
      end else begin
        c_nxt[i] = sh[i][COMPONENT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      c_r   <= c_nxt;
      sat_r <= |clip;
    end
  end

  assign out_valid = v6_r;
  assign prod_w    = c_r[qprod_pkg::COMP_W];
  assign prod_x    = c_r[qprod_pkg::COMP_X];
  assign prod_y    = c_r[qprod_pkg::COMP_Y];
  assign prod_z    = c_r[qprod_pkg::COMP_Z];
  assign saturated = sat_r;

endmodule

### rtl/core/quaternion_product_top.sv
// Top level of the fixed-point quaternion Hamilton product pipeline.
// An accepted transaction passes six register stages, each with its own valid bit.
// Throughput: one transaction per cycle while out_stall is low.
// A stalled output holds its result; empty stages still fill behind it.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers keep no reset.
module quaternion_product_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_left_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_left_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_left_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_left_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_right_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_right_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_right_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_right_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_prod_w,
  output logic signed [COMPONENT_WIDTH-1:0] out_prod_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_prod_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_prod_z,
  output logic                              out_saturated
);

  logic signed [2*COMPONENT_WIDTH+1:0] prod [qprod_pkg::NUM_PROD];
  logic signed [2*COMPONENT_WIDTH+5:0] sum  [qprod_pkg::NUM_COMP];
  logic                                in_ready;
  logic                                mul_valid, mul_ready;
  logic                                cmb_valid, cmb_ready;

  assign in_stall = !in_ready;

  qprod_mul #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(in_valid),
    .up_ready(in_ready),
    .left_w  (in_left_w),
    .left_x  (in_left_x),
    .left_y  (in_left_y),
    .left_z  (in_left_z),
    .right_w (in_right_w),
    .right_x (in_right_x),
    .right_y (in_right_y),
    .right_z (in_right_z),
    .dn_valid(mul_valid),
    .dn_ready(mul_ready),
    .prod    (prod)
  );

  qprod_combine #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(mul_valid),
    .up_ready(mul_ready),
    .prod    (prod),
    .dn_valid(cmb_valid),
    .dn_ready(cmb_ready),
    .sum     (sum)
  );

  qprod_round #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cmb_valid),
    .up_ready (cmb_ready),
    .sum      (sum),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prod_w   (out_prod_w),
    .prod_x   (out_prod_x),
    .prod_y   (out_prod_y),
    .prod_z   (out_prod_z),
    .saturated(out_saturated)
  );

endmodule

### rtl/core/qprod_checker.sv
// Port-level checker for the quaternion product top level, with its bind.
module qprod_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [COMPONENT_WIDTH-1:0] out_prod_w,
  input logic signed [COMPONENT_WIDTH-1:0] out_prod_x,
  input logic signed [COMPONENT_WIDTH-1:0] out_prod_y,
  input logic signed [COMPONENT_WIDTH-1:0] out_prod_z,
  input logic                              out_saturated
);

  localparam logic signed [COMPONENT_WIDTH-1:0] MAX_VAL =
    {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [COMPONENT_WIDTH-1:0] MIN_VAL =
    {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_prod_w) && $stable(out_prod_x) &&
      $stable(out_prod_y) && $stable(out_prod_z) && $stable(out_saturated))
    else $error("stalled result changed");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_prod_w == MAX_VAL || out_prod_w == MIN_VAL ||
      out_prod_x == MAX_VAL || out_prod_x == MIN_VAL ||
      out_prod_y == MAX_VAL || out_prod_y == MIN_VAL ||
      out_prod_z == MAX_VAL || out_prod_z == MIN_VAL)
    else $error("saturation flagged with no component at a limit");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

endmodule

bind quaternion_product_top qprod_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_qprod_checker (.*);
